// File: hdl/kcu_pkg.sv
// Package for the centroid update core: field widths, command and register
// codes, shared types. No dependencies.
package kcu_pkg;

  localparam int COORD_W = 32;
  localparam int SUM_W   = 48;
  localparam int CMD_W   = 2;
  localparam int CL_W    = 3;
  localparam int DIM_W   = 2;
  localparam int CFG_W   = 4;
  localparam int AC_W    = 4;
  localparam int AD_W    = 3;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACCUM  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;

  localparam logic REG_ACTIVE_CLUSTERS = 1'b0;
  localparam logic REG_ACTIVE_DIMS     = 1'b1;

  localparam logic [AC_W-1:0] AC_RESET = 4'd8;
  localparam logic [AD_W-1:0] AD_RESET = 3'd4;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hdl/kcu_ifs.sv
// Valid/ready channel interfaces for command items and emitted centers.
// Depends on kcu_pkg.
interface kcu_in_if;
  logic                       valid;
  logic                       ready;
  logic [kcu_pkg::CMD_W-1:0]  command;
  logic [kcu_pkg::CL_W-1:0]   cluster_index;
  logic [kcu_pkg::DIM_W-1:0]  dim_index;
  kcu_pkg::coord_t            coord_value;

  modport source (output valid, command, cluster_index, dim_index, coord_value,
                  input ready);
  modport sink (input valid, command, cluster_index, dim_index, coord_value,
                output ready);
endinterface

interface kcu_out_if;
  logic                       valid;
  logic                       ready;
  logic [kcu_pkg::CL_W-1:0]   out_cluster;
  logic [kcu_pkg::DIM_W-1:0]  out_dim;
  kcu_pkg::coord_t            center_value;
  logic                       moved;
  logic                       last;

  modport source (output valid, out_cluster, out_dim, center_value, moved, last,
                  input ready);
  modport sink (input valid, out_cluster, out_dim, center_value, moved, last,
                output ready);
endinterface

// File: hdl/kcu_divider.sv
// Restoring divider, one quotient bit per cycle: signed sum by unsigned count,
// truncating toward zero, saturated to a Q16.16 coordinate. Depends on kcu_pkg.
module kcu_divider #(
  parameter int DW = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  kcu_pkg::sum_t       dividend,
  input  logic [DW-1:0]       divisor,
  output kcu_pkg::coord_t     quotient,
  output kcu_pkg::div_stat_t  stat
);
  localparam int SW  = kcu_pkg::SUM_W;
  localparam int STW = $clog2(SW);

  logic           busy;
  logic           done;
  logic           neg;
  logic [SW-1:0]  qr;
  logic [DW-1:0]  rem;
  logic [DW-1:0]  dvs;
  logic [STW-1:0] step;

  logic [DW:0]    trial;
  logic [DW-1:0]  rem_next;
  logic           qbit;
  logic           big;

  always_comb begin
    trial = {rem, qr[SW-1]};
    if (trial >= {1'b0, dvs}) begin
      qbit     = 1'b1;
      rem_next = DW'(trial - {1'b0, dvs});
    end else begin
      qbit     = 1'b0;
      rem_next = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        neg  <= dividend[SW-1];
        qr   <= dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
        rem  <= '0;
        dvs  <= divisor;
        step <= '0;
      end else if (busy) begin
        rem  <= rem_next;
        qr   <= {qr[SW-2:0], qbit};
        step <= step + 1'b1;
        if (step == STW'(SW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    big = |qr[SW-1:32];
    if (!neg) begin
      quotient = (big || qr[31]) ? 32'sh7FFF_FFFF : signed'(qr[31:0]);
    end else begin
      quotient = (big || (qr[31] && |qr[30:0])) ? 32'sh8000_0000
                                                 : signed'(-qr[31:0]);
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: hdl/kmeans_centroid_update_core.sv
// Centroid update core. Load and accumulate transactions are taken one per
// cycle while idle: an accumulate reads its running sum from the sum memory,
// adds in the next cycle and writes back, with the last write forwarded to a
// following read of the same entry. An update transaction walks every active
// center coordinate: a memory read in S_RD, then a bit-serial divide over the
// 48-bit sum for clusters that collected points, then a result in S_OUT,
// which waits out any output stall. No new transaction is taken during the
// walk. Sums and counts start cleared at reset and are cleared at the end of
// each update; centers must be loaded before they are read.
module kmeans_centroid_update_core #(
  parameter int MAX_CLUSTERS = 8,
  parameter int MAX_DIMS     = 4,
  parameter int MAX_POINTS   = 65536
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [kcu_pkg::CFG_W-1:0]  cfg_data,
  kcu_in_if.sink                     item_in,
  kcu_out_if.source                  result_out
);
  localparam int NENT = MAX_CLUSTERS * MAX_DIMS;
  localparam int AW   = (NENT > 1) ? $clog2(NENT) : 1;
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int CIW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DIW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CLW  = $clog2(MAX_CLUSTERS + 1);
  localparam int DLW  = $clog2(MAX_DIMS + 1);
  localparam int CXW  = (CLW > kcu_pkg::AC_W) ? CLW : kcu_pkg::AC_W;
  localparam int DXW  = (DLW > kcu_pkg::AD_W) ? DLW : kcu_pkg::AD_W;
  localparam int SW   = kcu_pkg::SUM_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [kcu_pkg::AC_W-1:0] active_clusters;
  logic [kcu_pkg::AD_W-1:0] active_dims;
  logic [CXW-1:0] nc;
  logic [DXW-1:0] nd;

  kcu_pkg::coord_t center_mem [NENT];
  kcu_pkg::sum_t   sum_mem [NENT];
  kcu_pkg::coord_t center_rd;
  kcu_pkg::sum_t   sum_rd;
  logic [NENT-1:0] sum_vld;
  logic [CW-1:0]   cnt [MAX_CLUSTERS];
  logic            taken;
  logic [kcu_pkg::CL_W-1:0] taken_cl;
  logic            moved_flag;

  logic [1:0]      state;
  logic            ld_phase;
  logic [CIW-1:0]  uc;
  logic [DIW-1:0]  ud;
  logic [AW-1:0]   u_k;
  logic [CW-1:0]   cnt_u;
  kcu_pkg::coord_t old_c;
  kcu_pkg::sum_t   u_sum;

  logic            p1_vld;
  logic [AW-1:0]   p1_addr;
  kcu_pkg::coord_t p1_cv;
  logic            fwd_vld;
  logic [AW-1:0]   fwd_addr;
  kcu_pkg::sum_t   fwd_data;
  kcu_pkg::sum_t   p1_base;
  kcu_pkg::sum_t   p1_sum;

  logic            in_acc;
  logic [AW-1:0]   in_k;
  logic [CIW-1:0]  in_ci;
  logic            in_act;
  logic            in_inrange;
  logic            acc_add;
  logic [AW-1:0]   raddr;

  logic            div_start;
  kcu_pkg::coord_t div_q;
  kcu_pkg::div_stat_t div_stat;
  kcu_pkg::coord_t new_val;
  logic            chg;
  logic            last_ent;
  logic            out_free;
  logic            out_load;

  logic            out_vld;
  logic [kcu_pkg::CL_W-1:0]  out_cl;
  logic [kcu_pkg::DIM_W-1:0] out_dm;
  kcu_pkg::coord_t out_val;
  logic            out_moved;
  logic            out_last;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      active_clusters <= kcu_pkg::AC_RESET;
      active_dims     <= kcu_pkg::AD_RESET;
    end else if (cfg_we) begin
      if (cfg_index == kcu_pkg::REG_ACTIVE_CLUSTERS) begin
        active_clusters <= cfg_data;
      end else begin
        active_dims <= cfg_data[kcu_pkg::AD_W-1:0];
      end
    end
  end

  always_comb begin
    if (active_clusters == '0) nc = CXW'(1);
    else if (CXW'(active_clusters) > CXW'(MAX_CLUSTERS)) nc = CXW'(MAX_CLUSTERS);
    else nc = CXW'(active_clusters);
    if (active_dims == '0) nd = DXW'(1);
    else if (DXW'(active_dims) > DXW'(MAX_DIMS)) nd = DXW'(MAX_DIMS);
    else nd = DXW'(active_dims);
  end

  // input side
  assign item_in.ready = (state == S_IDLE);
  assign in_acc        = item_in.valid && item_in.ready;
  assign in_ci         = CIW'(item_in.cluster_index);
  assign in_k          = AW'(int'(item_in.cluster_index) * MAX_DIMS
                             + int'(item_in.dim_index));
  assign in_inrange    = (int'(item_in.cluster_index) < MAX_CLUSTERS)
                         && (int'(item_in.dim_index) < MAX_DIMS);
  assign in_act        = (CXW'(item_in.cluster_index) < nc)
                         && (DXW'(item_in.dim_index) < nd);

  always_comb begin
    acc_add = 1'b0;
    if (in_acc && item_in.command == kcu_pkg::CMD_ACCUM && in_act) begin
      if (item_in.dim_index == '0) begin
        acc_add = (cnt[in_ci] < CW'(MAX_POINTS));
      end else begin
        acc_add = taken && (taken_cl == item_in.cluster_index);
      end
    end
  end

  // read-modify-write of sums
  always_comb begin
    if (fwd_vld && fwd_addr == p1_addr) p1_base = fwd_data;
    else if (sum_vld[p1_addr]) p1_base = sum_rd;
    else p1_base = '0;
    p1_sum = p1_base + SW'(p1_cv);
  end

  assign raddr = (state == S_IDLE) ? in_k : u_k;

  always_ff @(posedge clk) begin
    sum_rd    <= sum_mem[raddr];
    center_rd <= center_mem[raddr];
    if (p1_vld) begin
      sum_mem[p1_addr] <= p1_sum;
    end
    if (in_acc && item_in.command == kcu_pkg::CMD_LOAD && in_inrange) begin
      center_mem[in_k] <= item_in.coord_value;
    end else if (out_load && cnt_u != '0) begin
      center_mem[u_k] <= new_val;
    end
  end

  always_ff @(posedge clk) begin
    p1_addr  <= in_k;
    p1_cv    <= item_in.coord_value;
    fwd_addr <= p1_addr;
    fwd_data <= p1_sum;
    if (rst) begin
      p1_vld  <= 1'b0;
      fwd_vld <= 1'b0;
      sum_vld <= '0;
    end else begin
      p1_vld  <= acc_add;
      fwd_vld <= p1_vld;
      if (p1_vld) begin
        sum_vld[p1_addr] <= 1'b1;
      end
      if (out_load && last_ent) begin
        sum_vld <= '0;
      end
    end
  end

  // counts and point tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) cnt[i] <= '0;
      taken    <= 1'b0;
      taken_cl <= '0;
    end else if (out_load && last_ent) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) cnt[i] <= '0;
      taken    <= 1'b0;
      taken_cl <= '0;
    end else if (in_acc && item_in.command == kcu_pkg::CMD_ACCUM && in_act
                 && item_in.dim_index == '0) begin
      if (cnt[in_ci] < CW'(MAX_POINTS)) begin
        cnt[in_ci] <= cnt[in_ci] + 1'b1;
        taken      <= 1'b1;
        taken_cl   <= item_in.cluster_index;
      end else begin
        taken <= 1'b0;
      end
    end
  end

  // update walk
  assign u_k      = AW'(int'(uc) * MAX_DIMS + int'(ud));
  assign cnt_u    = cnt[uc];
  assign div_start = (state == S_RD) && ld_phase && (cnt_u != '0);
  assign new_val  = (cnt_u != '0) ? div_q : old_c;
  assign chg      = (cnt_u != '0) && (new_val != old_c);
  assign last_ent = (CXW'(uc) + CXW'(1) == nc) && (DXW'(ud) + DXW'(1) == nd);
  assign out_free = !out_vld || result_out.ready;
  assign out_load = (state == S_OUT) && out_free;

  kcu_divider #(.DW(CW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (u_sum),
    .divisor  (cnt_u),
    .quotient (div_q),
    .stat     (div_stat)
  );

  always_comb begin
    u_sum = sum_vld[u_k] ? sum_rd : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ld_phase   <= 1'b0;
      uc         <= '0;
      ud         <= '0;
      moved_flag <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc && item_in.command == kcu_pkg::CMD_UPDATE) begin
            state      <= S_RD;
            ld_phase   <= 1'b0;
            uc         <= '0;
            ud         <= '0;
            moved_flag <= 1'b0;
          end
        end
        S_RD: begin
          if (!ld_phase) begin
            ld_phase <= 1'b1;
          end else begin
            ld_phase <= 1'b0;
            old_c    <= center_rd;
            state    <= (cnt_u != '0) ? S_DIV : S_OUT;
          end
        end
        S_DIV: begin
          if (div_stat.done) state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            moved_flag <= moved_flag | chg;
            if (last_ent) begin
              state <= S_IDLE;
            end else begin
              state <= S_RD;
              if (DXW'(ud) + DXW'(1) == nd) begin
                ud <= '0;
                uc <= uc + 1'b1;
              end else begin
                ud <= ud + 1'b1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_load) begin
      out_vld <= 1'b1;
    end else if (result_out.ready) begin
      out_vld <= 1'b0;
    end
    if (out_load) begin
      out_cl    <= kcu_pkg::CL_W'(uc);
      out_dm    <= kcu_pkg::DIM_W'(ud);
      out_val   <= new_val;
      out_moved <= last_ent && (moved_flag | chg);
      out_last  <= last_ent;
    end
  end

  assign result_out.valid        = out_vld;
  assign result_out.out_cluster  = out_cl;
  assign result_out.out_dim      = out_dm;
  assign result_out.center_value = out_val;
  assign result_out.moved        = out_moved;
  assign result_out.last         = out_last;

  a_no_rmw_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !p1_vld)
    else $error("sum write pending during update walk");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_walk_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && !result_out.last) |-> !item_in.ready)
    else $error("input taken while update results remain");

endmodule

// File: dv/tb.sv
// Self-checking testbench for kmeans_centroid_update_core: directed table, then
// random point sequences under several configs with output back-pressure.
// Depends on kcu_pkg and the channel interfaces in kcu_ifs.
module tb;

  localparam logic [kcu_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int NCL = 8;
  localparam int NDM = 4;
  localparam int FULL_COUNT = 65536;

  typedef struct {
    logic [kcu_pkg::CL_W-1:0]  cl;
    logic [kcu_pkg::DIM_W-1:0] dm;
    logic [31:0]      value;
    logic             moved;
    logic             last;
  } center_t;

  typedef struct {
    logic [kcu_pkg::CMD_W-1:0] cmd;
    logic [kcu_pkg::CL_W-1:0]  cl;
    logic [kcu_pkg::DIM_W-1:0] dm;
    logic [31:0]      value;
    bit               chk;
    logic [31:0]      want;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [kcu_pkg::CFG_W-1:0] cfg_data = '0;

  kcu_in_if  items_ch();
  kcu_out_if centers_ch();

  kmeans_centroid_update_core u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_in    (items_ch),
    .result_out (centers_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0]  center_mem [NCL*NDM];
  logic [47:0]  sum_mem [NCL*NDM];
  int unsigned  pts [NCL];
  bit           taken;
  int unsigned  taken_cl;
  int unsigned  clusters_reg = kcu_pkg::AC_RESET;
  int unsigned  dims_reg = kcu_pkg::AD_RESET;
  center_t      centers_due [$];

  int mism = 0;
  int n_items = 0;
  int n_centers = 0;
  int n_updates = 0;
  bit pace_on = 1;
  int burst_left = 0;
  bit hold_req = 0;
  int hold_left = 0;
  logic [7:0] rx_cnt = 0;

  function automatic int unsigned clampv(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void apply_item(logic [kcu_pkg::CMD_W-1:0] cmd,
                                     logic [kcu_pkg::CL_W-1:0] cl,
                                     logic [kcu_pkg::DIM_W-1:0] dm, logic [31:0] value);
    int unsigned nc, nd, k;
    bit add, mv;
    longint s, q;
    center_t e;
    nc = clampv(clusters_reg, NCL);
    nd = clampv(dims_reg, NDM);
    case (cmd)
      kcu_pkg::CMD_LOAD: center_mem[cl*NDM+dm] = value;
      kcu_pkg::CMD_ACCUM: begin
        if (cl < nc && dm < nd) begin
          add = 0;
          if (dm == 0) begin
            if (pts[cl] < FULL_COUNT) begin
              pts[cl]++;
              taken = 1;
              taken_cl = cl;
              add = 1;
            end else begin
              taken = 0;
            end
          end else if (taken && taken_cl == cl) begin
            add = 1;
          end
          if (add) begin
            k = cl*NDM + dm;
            sum_mem[k] = sum_mem[k] + {{16{value[31]}}, value};
          end
        end
      end
      kcu_pkg::CMD_UPDATE: begin
        mv = 0;
        n_updates++;
        for (int c = 0; c < nc; c++) begin
          for (int d = 0; d < nd; d++) begin
            k = c*NDM + d;
            e.value = center_mem[k];
            if (pts[c] != 0) begin
              s = $signed(sum_mem[k]);
              q = s / longint'(pts[c]);
              if (q > 64'sd2147483647) q = 64'sd2147483647;
              if (q < -64'sd2147483648) q = -64'sd2147483648;
              if (q[31:0] != e.value) mv = 1;
              e.value = q[31:0];
              center_mem[k] = q[31:0];
            end
            e.cl = kcu_pkg::CL_W'(c);
            e.dm = kcu_pkg::DIM_W'(d);
            e.last = (c == nc-1) && (d == nd-1);
            e.moved = e.last ? mv : 1'b0;
            centers_due.push_back(e);
          end
        end
        for (int i = 0; i < NCL*NDM; i++) sum_mem[i] = '0;
        for (int i = 0; i < NCL; i++) pts[i] = 0;
        taken = 0;
        taken_cl = 0;
      end
      default: ;
    endcase
  endfunction

  task automatic send(logic [kcu_pkg::CMD_W-1:0] cmd, logic [kcu_pkg::CL_W-1:0] cl,
                      logic [kcu_pkg::DIM_W-1:0] dm, logic [31:0] value);
    int gap;
    @(negedge clk);
    items_ch.command <= cmd;
    items_ch.cluster_index <= cl;
    items_ch.dim_index <= dm;
    items_ch.coord_value <= value;
    items_ch.valid <= 1'b1;
    do @(posedge clk); while (!items_ch.ready);
    apply_item(cmd, cl, dm, value);
    n_items++;
    if (pace_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
        @(negedge clk) items_ch.valid <= 1'b0;
        repeat (gap-1) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic write_reg(logic idx, int unsigned value);
    @(negedge clk) items_ch.valid <= 1'b0;
    while (centers_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[kcu_pkg::CFG_W-1:0];
    @(negedge clk) cfg_we <= 1'b0;
    if (idx == kcu_pkg::REG_ACTIVE_CLUSTERS) clusters_reg = value & 4'hF;
    else dims_reg = value & 3'h7;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  // receiver stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 600;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      centers_ch.ready <= 1'b0;
    end else begin
      rx_cnt <= rx_cnt + 1;
      case (rx_cnt[7:6])
        2'd0: centers_ch.ready <= 1'b1;
        2'd1: centers_ch.ready <= 1'($urandom_range(0, 1));
        2'd2: centers_ch.ready <= ($urandom_range(0, 3) == 0);
        default: centers_ch.ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    center_t e;
    if (!rst && centers_ch.valid && centers_ch.ready) begin
      n_centers++;
      if (centers_due.size() == 0) begin
        mism++;
        if (mism <= 10)
          $display("unexpected center: cl %0d dim %0d value %h moved %b last %b",
                   centers_ch.out_cluster, centers_ch.out_dim, centers_ch.center_value,
                   centers_ch.moved, centers_ch.last);
      end else begin
        e = centers_due.pop_front();
        if (e.cl !== centers_ch.out_cluster || e.dm !== centers_ch.out_dim ||
            e.value !== centers_ch.center_value || e.moved !== centers_ch.moved ||
            e.last !== centers_ch.last) begin
          mism++;
          if (mism <= 10)
            $display("center mismatch: exp cl %0d dim %0d %h m%b l%b, got cl %0d dim %0d %h m%b l%b",
                     e.cl, e.dm, e.value, e.moved, e.last,
                     centers_ch.out_cluster, centers_ch.out_dim, centers_ch.center_value,
                     centers_ch.moved, centers_ch.last);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  row_t dir_rows [19] = '{
    '{kcu_pkg::CMD_UPDATE, 3'd0, 2'd0, 32'h0,          1, 32'h001F_0000},
    '{kcu_pkg::CMD_ACCUM,  3'd0, 2'd0, 32'h7FFF_FFFF,  0, 32'h0},
    '{kcu_pkg::CMD_ACCUM,  3'd0, 2'd1, 32'h8000_0000,  0, 32'h0},
    '{kcu_pkg::CMD_ACCUM,  3'd0, 2'd2, 32'h0000_0001,  0, 32'h0},
    '{kcu_pkg::CMD_ACCUM,  3'd0, 2'd3, 32'hFFFF_FFFF,  0, 32'h0},
    '{kcu_pkg::CMD_ACCUM,  3'd0, 2'd0, 32'h0001_0000,  0, 32'h0},
    '{kcu_pkg::CMD_ACCUM,  3'd1, 2'd1, 32'h0000_0005,  0, 32'h0},
    '{kcu_pkg::CMD_ACCUM,  3'd7, 2'd0, 32'h0,          0, 32'h0},
    '{kcu_pkg::CMD_ACCUM,  3'd7, 2'd3, 32'h7FFF_FFFF,  0, 32'h0},
    '{kcu_pkg::CMD_ACCUM,  3'd7, 2'd3, 32'h7FFF_FFFF,  0, 32'h0},
    '{kcu_pkg::CMD_ACCUM,  3'd7, 2'd3, 32'h7FFF_FFFF,  0, 32'h0},
    '{CMD_NONE,            3'd7, 2'd3, 32'hDEAD_BEEF,  0, 32'h0},
    '{kcu_pkg::CMD_UPDATE, 3'd0, 2'd0, 32'h0,          1, 32'h7FFF_FFFF},
    '{kcu_pkg::CMD_LOAD,   3'd7, 2'd3, 32'h8000_0000,  0, 32'h0},
    '{kcu_pkg::CMD_ACCUM,  3'd7, 2'd0, 32'h0,          0, 32'h0},
    '{kcu_pkg::CMD_ACCUM,  3'd7, 2'd3, 32'h8000_0000,  0, 32'h0},
    '{kcu_pkg::CMD_ACCUM,  3'd7, 2'd3, 32'h8000_0000,  0, 32'h0},
    '{kcu_pkg::CMD_UPDATE, 3'd0, 2'd0, 32'h0,          1, 32'h8000_0000},
    '{kcu_pkg::CMD_UPDATE, 3'd0, 2'd0, 32'h0,          1, 32'h8000_0000}
  };

  int unsigned cfg_list [8][2] = '{'{8, 4}, '{1, 1}, '{0, 0}, '{15, 7},
                                   '{3, 2}, '{6, 3}, '{8, 4}, '{2, 4}};

  initial begin
    int used, r, nc, nd, cl;
    items_ch.valid = 1'b0;
    items_ch.command = kcu_pkg::CMD_LOAD;
    items_ch.cluster_index = '0;
    items_ch.dim_index = '0;
    items_ch.coord_value = '0;
    centers_ch.ready = 1'b0;
    for (int i = 0; i < NCL*NDM; i++) begin
      center_mem[i] = '0;
      sum_mem[i] = '0;
    end
    for (int i = 0; i < NCL; i++) pts[i] = 0;
    taken = 0;
    taken_cl = 0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // every center gets a known value before any update reads it
    for (int i = 0; i < NCL*NDM; i++)
      send(kcu_pkg::CMD_LOAD, kcu_pkg::CL_W'(i / NDM), kcu_pkg::DIM_W'(i % NDM), i << 16);

    foreach (dir_rows[i]) begin
      send(dir_rows[i].cmd, dir_rows[i].cl, dir_rows[i].dm, dir_rows[i].value);
      if (dir_rows[i].chk && centers_due[$].value !== dir_rows[i].want) begin
        mism++;
        if (mism <= 10)
          $display("row %0d: predicted %h, table says %h", i, centers_due[$].value,
                   dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(kcu_pkg::REG_ACTIVE_CLUSTERS,
                ph < 7 ? cfg_list[ph][0] : $urandom_range(0, 15));
      write_reg(kcu_pkg::REG_ACTIVE_DIMS, ph < 7 ? cfg_list[ph][1] : $urandom_range(0, 7));
      nc = clampv(clusters_reg, NCL);
      nd = clampv(dims_reg, NDM);
      used = 0;
      // long receiver hold-off: two updates fill the output and stall the input
      if (ph == 2) begin
        hold_req = 1;
        send(kcu_pkg::CMD_UPDATE, 3'd0, 2'd0, 32'h0);
        send(kcu_pkg::CMD_UPDATE, 3'd0, 2'd0, 32'h0);
      end
      while (used < 32) begin
        r = $urandom_range(0, 19);
        if (r < 13) begin
          cl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, nc-1);
          for (int d = 0; d < nd; d++)
            send(kcu_pkg::CMD_ACCUM, kcu_pkg::CL_W'(cl), kcu_pkg::DIM_W'(d), rand_coord());
          used += nd;
        end else if (r < 15) begin
          send(kcu_pkg::CMD_LOAD, kcu_pkg::CL_W'($urandom_range(0, 7)),
               kcu_pkg::DIM_W'($urandom_range(0, 3)), rand_coord());
          used++;
        end else if (r < 17) begin
          send(kcu_pkg::CMD_W'($urandom_range(0, 3)), kcu_pkg::CL_W'($urandom_range(0, 7)),
               kcu_pkg::DIM_W'($urandom_range(0, 3)), $urandom);
          used++;
        end else begin
          send(kcu_pkg::CMD_UPDATE, kcu_pkg::CL_W'($urandom_range(0, 7)),
               kcu_pkg::DIM_W'($urandom_range(0, 3)), $urandom);
          used++;
        end
      end
      send(kcu_pkg::CMD_UPDATE, 3'd0, 2'd0, 32'h0);
    end

    @(negedge clk) items_ch.valid <= 1'b0;
    while (centers_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Ran %0d transactions in and %0d centers out over %0d updates,", n_items,
             n_centers, n_updates);
    $display("including quotient clipping, empty clusters, a long output stall and 8 configs.");
    if (mism == 0 && centers_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/kcu_pkg.sv
hdl/kcu_ifs.sv
hdl/kcu_divider.sv
hdl/kmeans_centroid_update_core.sv
dv/tb.sv
